@@ sv/bounded_deque_with_insert_defines.svh @@
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_WITH_INSERT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INSERT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/bdq_pkg.sv @@
// Types and constants of the bounded deque.
`default_nettype none

package bdq_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;
    localparam int POS_W  = 6;
    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [CNT_W-1:0]         at;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ sv/bdq_if.sv @@
// Request and result channel interfaces of the bounded deque.
`default_nettype none

interface bdq_req_if;
    logic                              valid;
    logic                              ready;
    logic [bdq_pkg::MODE_W-1:0]        mode;
    logic signed [bdq_pkg::DATA_W-1:0] value;
    logic [bdq_pkg::POS_W-1:0]         position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface bdq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [bdq_pkg::CNT_W-1:0] count;

    modport source (output valid, status, count, input ready);
    modport sink   (input valid, status, count, output ready);
endinterface

`default_nettype wire

@@ sv/bdq_cell.sv @@
// One storage cell of the deque row.
`default_nettype none

module bdq_cell #(
    parameter int IDX = 0
) (
    input  wire logic                              i_clk,
    input  wire bdq_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] i_prev,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] i_next,
    output logic signed [bdq_pkg::DATA_W-1:0]      o_data
);

    localparam logic [bdq_pkg::CNT_W-1:0] MY_IDX = bdq_pkg::CNT_W'(IDX);

    logic signed [bdq_pkg::DATA_W-1:0] r_data;
    logic signed [bdq_pkg::DATA_W-1:0] n_data;

    // Shift up past the insert point, take the new value at it, shift down on a drop.
    always_comb begin
        n_data = r_data;
        priority if (i_ctrl.ins && (MY_IDX > i_ctrl.at)) begin
            n_data = i_prev;
        end else if (i_ctrl.ins && (MY_IDX == i_ctrl.at)) begin
            n_data = i_ctrl.value;
        end else if (i_ctrl.del && (MY_IDX >= i_ctrl.at)) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ sv/bdq_ctrl.sv @@
// Operation decode, status and fill count of the deque.
`default_nettype none

module bdq_ctrl #(
    parameter int CAPACITY = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic [bdq_pkg::MODE_W-1:0]        i_mode,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] i_value,
    input  wire logic [bdq_pkg::POS_W-1:0]         i_position,
    output bdq_pkg::t_cell_ctrl                    o_ctrl,
    output bdq_pkg::t_status                       o_status,
    output logic [bdq_pkg::CNT_W-1:0]              o_count
);

    localparam logic [bdq_pkg::CNT_W-1:0] CAP = bdq_pkg::CNT_W'(CAPACITY);

    logic [bdq_pkg::CNT_W-1:0] r_count;
    logic [bdq_pkg::CNT_W-1:0] n_count;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_ins;
    logic                      w_del;
    logic [bdq_pkg::CNT_W-1:0] w_at;
    bdq_pkg::t_status          w_status;

    assign w_full  = (r_count >= CAP);
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_at     = '0;
        w_status = bdq_pkg::ST_OK;
        unique case (bdq_pkg::t_mode'(i_mode))
            bdq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) w_status = bdq_pkg::ST_FULL;
                else        w_ins    = 1'b1;
            end
            bdq_pkg::MODE_PUSH_BACK: begin
                w_at = r_count;
                if (w_full) w_status = bdq_pkg::ST_FULL;
                else        w_ins    = 1'b1;
            end
            bdq_pkg::MODE_POP_FRONT: begin
                if (w_empty) w_status = bdq_pkg::ST_EMPTY;
                else         w_del    = 1'b1;
            end
            bdq_pkg::MODE_POP_BACK: begin
                w_at = r_count - bdq_pkg::CNT_W'(1);
                if (w_empty) w_status = bdq_pkg::ST_EMPTY;
                else         w_del    = 1'b1;
            end
            bdq_pkg::MODE_INSERT: begin
                w_at = i_position;
                priority if (i_position > r_count) w_status = bdq_pkg::ST_BADPOS;
                else if (w_full)                   w_status = bdq_pkg::ST_FULL;
                else                               w_ins    = 1'b1;
            end
            default: begin
                w_status = bdq_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_fire && w_ins) n_count = r_count + bdq_pkg::CNT_W'(1);
        if (i_fire && w_del) n_count = r_count - bdq_pkg::CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_ctrl.ins   = i_fire && w_ins;
    assign o_ctrl.del   = i_fire && w_del;
    assign o_ctrl.at    = w_at;
    assign o_ctrl.value = i_value;
    assign o_status     = w_status;
    assign o_count      = n_count;

endmodule

`default_nettype wire

@@ sv/bounded_deque_with_insert.sv @@
// Top level: bounded deque with positional insert, built as a row of shifting cells.
// The result of a request is valid in the cycle after the request is taken.
// One request per cycle unless a held result is not taken; every operation shifts the whole row at once.
// The result register takes a new request in the cycle its current result is taken.
// Reset (synchronous, active low) empties the list and drops any pending result;
// stored cell values are not cleared and are never visible at the ports.
`default_nettype none

module bounded_deque_with_insert #(
    parameter int CAPACITY = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    // Decode outputs for the current request.
    bdq_pkg::t_cell_ctrl       w_ctrl;
    bdq_pkg::t_status          w_status;
    logic [bdq_pkg::CNT_W-1:0] w_count;
    logic                      w_fire;

    // Row of cell contents, plus the left and right neighbor word seen by each cell.
    logic signed [bdq_pkg::DATA_W-1:0] w_data [CAPACITY];
    logic signed [bdq_pkg::DATA_W-1:0] w_prev [CAPACITY];
    logic signed [bdq_pkg::DATA_W-1:0] w_next [CAPACITY];

    // Result register.
    logic                      r_out_valid;
    logic                      n_out_valid;
    bdq_pkg::t_status          r_status;
    logic [bdq_pkg::CNT_W-1:0] r_count;

    // Take a request whenever the result register is empty or is being drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;

    bdq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_mode     (i_req.mode),
        .i_value    (i_req.value),
        .i_position (i_req.position),
        .o_ctrl     (w_ctrl),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    // Wire each cell to its neighbors; the front has no left neighbor and the
    // back no right one, so tie those ends off.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_front
            assign w_prev[g] = '0;
        end else begin : g_mid_prev
            assign w_prev[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_back
            assign w_next[g] = '0;
        end else begin : g_mid_next
            assign w_next[g] = w_data[g+1];
        end

        bdq_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_prev (w_prev[g]),
            .i_next (w_next[g]),
            .o_data (w_data[g])
        );
    end

    // Hold the result until taken; load a new one on every accepted request.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) n_out_valid = 1'b0;
        if (w_fire)      n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            r_count  <= w_count;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = r_count;

endmodule

`default_nettype wire

@@ sv/bdq_checker.sv @@
// Port-level checks of the bounded deque, attached by bind.
`default_nettype none
`include "bounded_deque_with_insert_defines.svh"

module bdq_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic                       o_rsp_valid,
    input wire logic [1:0]                 o_rsp_status,
    input wire logic [bdq_pkg::CNT_W-1:0]  o_rsp_count
);

    localparam logic [bdq_pkg::CNT_W-1:0] CAP = bdq_pkg::CNT_W'(CAPACITY);

    `BDQ_ASSERT(a_count_bound, !o_rsp_valid || (o_rsp_count <= CAP), "count above capacity")
    `BDQ_ASSERT(a_full_count, !(o_rsp_valid && (o_rsp_status == bdq_pkg::ST_FULL)) || (o_rsp_count == CAP), "full reported below capacity")
    `BDQ_ASSERT(a_empty_count, !(o_rsp_valid && (o_rsp_status == bdq_pkg::ST_EMPTY)) || (o_rsp_count == '0), "empty reported with stored values")
    `BDQ_ASSERT_NEXT(a_result_follows, i_req_valid && i_req_ready, o_rsp_valid, "no result after request")

endmodule

bind bounded_deque_with_insert bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .o_rsp_valid  (o_rsp.valid),
    .o_rsp_status (o_rsp.status),
    .o_rsp_count  (o_rsp.count)
);

`default_nettype wire
